>>> hw/rtl/pcx_rle_pkg.sv
`timescale 1ns / 1ps

package pcx_rle_pkg;

	localparam int BYTE_W  = 8;
	localparam int COUNT_W = 6;
	localparam int CFG_W   = 13;
	localparam int DATA_W  = 32;
	localparam int ADDR_W  = 3;

	localparam logic [BYTE_W-1:0] PREFIX_MASK = 8'hC0;

	localparam logic REG_WIDTH  = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;

	localparam logic [CFG_W-1:0] WIDTH_RST  = 13'd640;
	localparam logic [CFG_W-1:0] HEIGHT_RST = 13'd480;

	// cycles for the image limit to follow a size write
	localparam logic [1:0] LIM_SETTLE = 2'd2;

	typedef struct packed {
		logic accept;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic lim_ok;
		logic will_emit;
		logic last;
	} sts_t;

endpackage

>>> hw/rtl/pcx_rle_if.sv
`timescale 1ns / 1ps

interface pcx_rle_in_if;
	logic                            valid;
	logic                            ready;
	logic [pcx_rle_pkg::BYTE_W-1:0]  code_byte;
	logic                            start_of_image;
	logic                            end_of_stream;

	modport source (output valid, code_byte, start_of_image, end_of_stream, input ready);
	modport sink (input valid, code_byte, start_of_image, end_of_stream, output ready);
endinterface

interface pcx_rle_out_if;
	logic                            valid;
	logic                            ready;
	logic [pcx_rle_pkg::BYTE_W-1:0]  pixel_byte;
	logic                            last_of_run;
	logic                            image_complete;

	modport source (output valid, pixel_byte, last_of_run, image_complete, input ready);
	modport sink (input valid, pixel_byte, last_of_run, image_complete, output ready);
endinterface

>>> hw/rtl/pcx_rle_ctrl.sv
`timescale 1ns / 1ps

module pcx_rle_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	input  pcx_rle_pkg::sts_t  sts,
	output pcx_rle_pkg::cmd_t  cmd
);

	typedef enum logic {
		IDLE,
		EMIT
	} state_t;

	state_t state_q;

	assign in_ready   = (state_q == IDLE) && sts.lim_ok;
	assign out_valid  = (state_q == EMIT);
	assign cmd.accept = in_valid && in_ready;
	assign cmd.emit   = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
		end else begin
			unique case (state_q)
				IDLE: begin
					if (cmd.accept && sts.will_emit) begin
						state_q <= EMIT;
					end
				end
				EMIT: begin
					if (cmd.emit && sts.last) begin
						state_q <= IDLE;
					end
				end
				default: state_q <= IDLE;
			endcase
		end
	end

endmodule

>>> hw/rtl/pcx_rle_dp.sv
`timescale 1ns / 1ps

module pcx_rle_dp #(
	parameter int BYTES_PER_PIXEL = 3,
	parameter int MAX_SIDE        = 4096
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [pcx_rle_pkg::ADDR_W-1:0]      paddr,
	input  logic [pcx_rle_pkg::DATA_W-1:0]      pwdata,
	output logic [pcx_rle_pkg::DATA_W-1:0]      prdata,
	input  logic [pcx_rle_pkg::BYTE_W-1:0]      code_byte,
	input  logic                                start_of_image,
	input  logic                                end_of_stream,
	input  pcx_rle_pkg::cmd_t                   cmd,
	output pcx_rle_pkg::sts_t                   sts,
	output logic [pcx_rle_pkg::BYTE_W-1:0]      pixel_byte,
	output logic                                last_of_run,
	output logic                                image_complete
);

	localparam int SIDE_RAW = $clog2(MAX_SIDE + 1);
	localparam int SIDE_W   = (SIDE_RAW < pcx_rle_pkg::CFG_W) ? SIDE_RAW : pcx_rle_pkg::CFG_W;
	localparam int BPP_W    = $clog2(BYTES_PER_PIXEL + 1);
	localparam int CNT_W    = 2 * SIDE_W + BPP_W;

	logic [pcx_rle_pkg::CFG_W-1:0]   width_q;
	logic [pcx_rle_pkg::CFG_W-1:0]   height_q;
	logic [SIDE_W-1:0]               width_c;
	logic [SIDE_W-1:0]               height_c;
	logic [2*SIDE_W-1:0]             area_q;
	logic [CNT_W-1:0]                lim_q;
	logic [1:0]                      settle_q;
	logic                            cfg_wr;

	logic                            awaiting_q;
	logic [pcx_rle_pkg::COUNT_W-1:0] pending_q;
	logic [CNT_W-1:0]                written_q;
	logic                            done_q;
	logic [pcx_rle_pkg::BYTE_W-1:0]  byte_q;
	logic [pcx_rle_pkg::COUNT_W-1:0] run_q;

	logic                            aw_eff;
	logic [pcx_rle_pkg::COUNT_W-1:0] pend_eff;
	logic                            full_eff;
	logic                            is_prefix;
	logic [CNT_W-1:0]                written_inc;
	logic                            hit_lim;

	assign cfg_wr = psel && penable && pwrite;

	always_comb begin
		if (width_q == '0) begin
			width_c = SIDE_W'(1);
		end else if (32'(width_q) > 32'(MAX_SIDE)) begin
			width_c = SIDE_W'(MAX_SIDE);
		end else begin
			width_c = width_q[SIDE_W-1:0];
		end
		if (height_q == '0) begin
			height_c = SIDE_W'(1);
		end else if (32'(height_q) > 32'(MAX_SIDE)) begin
			height_c = SIDE_W'(MAX_SIDE);
		end else begin
			height_c = height_q[SIDE_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= pcx_rle_pkg::WIDTH_RST;
			height_q <= pcx_rle_pkg::HEIGHT_RST;
			settle_q <= pcx_rle_pkg::LIM_SETTLE;
		end else begin
			if (cfg_wr) begin
				if (paddr[2] == pcx_rle_pkg::REG_WIDTH) begin
					width_q <= pwdata[pcx_rle_pkg::CFG_W-1:0];
				end else begin
					height_q <= pwdata[pcx_rle_pkg::CFG_W-1:0];
				end
				settle_q <= pcx_rle_pkg::LIM_SETTLE;
			end else if (settle_q != '0) begin
				settle_q <= settle_q - 2'd1;
			end
		end
	end

	// limit in two registered steps: area, then bytes per pixel
	always_ff @(posedge clk) begin
		area_q <= (2*SIDE_W)'(width_c) * (2*SIDE_W)'(height_c);
		lim_q  <= CNT_W'(area_q) * CNT_W'(BYTES_PER_PIXEL);
	end

	always_comb begin
		prdata = '0;
		if (paddr[2] == pcx_rle_pkg::REG_WIDTH) begin
			prdata[pcx_rle_pkg::CFG_W-1:0] = width_q;
		end else begin
			prdata[pcx_rle_pkg::CFG_W-1:0] = height_q;
		end
	end

	assign aw_eff      = start_of_image ? 1'b0 : awaiting_q;
	assign pend_eff    = start_of_image ? '0 : pending_q;
	assign full_eff    = !start_of_image && (done_q || (written_q >= lim_q));
	assign is_prefix   = (code_byte & pcx_rle_pkg::PREFIX_MASK) == pcx_rle_pkg::PREFIX_MASK;
	assign written_inc = written_q + CNT_W'(1);
	assign hit_lim     = (written_inc == lim_q);

	always_comb begin
		sts.lim_ok = (settle_q == '0);
		if (full_eff) begin
			sts.will_emit = 1'b0;
		end else if (aw_eff) begin
			sts.will_emit = (pend_eff != '0);
		end else begin
			sts.will_emit = !is_prefix;
		end
		sts.last = (run_q == pcx_rle_pkg::COUNT_W'(1)) || hit_lim;
	end

	assign pixel_byte     = byte_q;
	assign last_of_run    = sts.last;
	assign image_complete = hit_lim;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			awaiting_q <= 1'b0;
			pending_q  <= '0;
			written_q  <= '0;
			done_q     <= 1'b0;
			run_q      <= '0;
		end else if (cmd.accept) begin
			if (start_of_image) begin
				written_q <= '0;
			end
			done_q     <= full_eff;
			awaiting_q <= 1'b0;
			pending_q  <= '0;
			if (!full_eff) begin
				if (aw_eff) begin
					run_q <= pend_eff;
				end else if (is_prefix) begin
					// a prefix on the final word is dropped
					awaiting_q <= !end_of_stream;
					pending_q  <= end_of_stream ? '0 : code_byte[pcx_rle_pkg::COUNT_W-1:0];
				end else begin
					run_q <= pcx_rle_pkg::COUNT_W'(1);
				end
			end
		end else if (cmd.emit) begin
			written_q <= written_inc;
			run_q     <= run_q - pcx_rle_pkg::COUNT_W'(1);
			if (hit_lim) begin
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			byte_q <= code_byte;
		end
	end

endmodule

>>> hw/rtl/pcx_rle_decoder_top.sv
`timescale 1ns / 1ps
// latency: first decoded byte is valid the cycle after its code word is taken
// flow: no code word is taken while the bytes of the last one are still being emitted,
// and the receiver can stall each byte; a run is counted down by the single run counter
// a code word producing no bytes (prefix, zero run, full image) leaves the block idle
// reset: arst_n clears all decoding state but the byte and limit registers and sets the size to 640 x 480;
// no word is taken after reset or a size write until the settle counter has run down

module pcx_rle_decoder_top #(
	parameter int BYTES_PER_PIXEL = 3,
	parameter int MAX_SIDE        = 4096
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [pcx_rle_pkg::ADDR_W-1:0]  paddr,
	input  logic [pcx_rle_pkg::DATA_W-1:0]  pwdata,
	output logic [pcx_rle_pkg::DATA_W-1:0]  prdata,
	output logic                            pready,
	pcx_rle_in_if.sink                      code_in,
	pcx_rle_out_if.source                   pix_out
);

	pcx_rle_pkg::cmd_t cmd;
	pcx_rle_pkg::sts_t sts;

	assign pready = 1'b1;

	pcx_rle_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (code_in.valid),
		.in_ready  (code_in.ready),
		.out_valid (pix_out.valid),
		.out_ready (pix_out.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	pcx_rle_dp #(
		.BYTES_PER_PIXEL (BYTES_PER_PIXEL),
		.MAX_SIDE        (MAX_SIDE)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.code_byte      (code_in.code_byte),
		.start_of_image (code_in.start_of_image),
		.end_of_stream  (code_in.end_of_stream),
		.cmd            (cmd),
		.sts            (sts),
		.pixel_byte     (pix_out.pixel_byte),
		.last_of_run    (pix_out.last_of_run),
		.image_complete (pix_out.image_complete)
	);

endmodule

>>> sim/tb_pcx_rle_decoder_top.sv
`timescale 1ns / 1ps

module tb_pcx_rle_decoder_top;

	localparam int PX_BYTES       = 3;
	localparam int SIDE_MAX       = 4096;
	localparam int RANDOM_WORDS   = 480;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int REPORT_MAX     = 10;
	localparam int SETTLE_CYCLES  = 4;

	localparam logic [pcx_rle_pkg::ADDR_W-1:0] WIDTH_ADDR  = {pcx_rle_pkg::REG_WIDTH, 2'b00};
	localparam logic [pcx_rle_pkg::ADDR_W-1:0] HEIGHT_ADDR = {pcx_rle_pkg::REG_HEIGHT, 2'b00};

	typedef logic [pcx_rle_pkg::CFG_W-1:0]  size_t;
	typedef logic [pcx_rle_pkg::DATA_W-1:0] apb_data_t;

	typedef struct packed {
		logic [pcx_rle_pkg::BYTE_W-1:0] code;
		logic                           sof;
		logic                           eos;
	} code_word_t;

	typedef struct packed {
		logic [pcx_rle_pkg::BYTE_W-1:0] pixel;
		logic                           run_end;
		logic                           img_full;
	} pix_word_t;

	logic                           clk;
	logic                           arst_n;
	logic                           psel;
	logic                           penable;
	logic                           pwrite;
	logic [pcx_rle_pkg::ADDR_W-1:0] paddr;
	apb_data_t                      pwdata;
	apb_data_t                      prdata;
	logic                           pready;

	pcx_rle_in_if  code_if();
	pcx_rle_out_if pix_if();

	pcx_rle_decoder_top #(
		.BYTES_PER_PIXEL(PX_BYTES),
		.MAX_SIDE(SIDE_MAX)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.code_in(code_if),
		.pix_out(pix_if)
	);

	code_word_t code_words[$];
	pix_word_t  want_pixels[$];

	// decoder state as the block should hold it
	size_t       size_w = pcx_rle_pkg::WIDTH_RST;
	size_t       size_h = pcx_rle_pkg::HEIGHT_RST;
	logic        waiting_value = 1'b0;
	logic [5:0]  run_len = '0;
	logic [31:0] bytes_out = '0;
	logic        full = 1'b0;

	int words_sent = 0;
	int words_taken = 0;
	int words_decoded = 0;
	int pixels_checked = 0;
	int images_seen = 0;
	int size_writes = 0;
	int err_count = 0;
	int idle_cycles = 0;

	code_word_t  on_bus;
	int          burst_left = 0;
	int          gap_left = 0;
	logic [15:0] ready_pat = '1;
	int          pat_pos = 0;

	function automatic logic [31:0] side_clamp(size_t v);
		if (v == 0)
			return 32'd1;
		if (v > SIDE_MAX)
			return 32'(SIDE_MAX);
		return 32'(v);
	endfunction

	function automatic logic [31:0] pixel_limit();
		return side_clamp(size_w) * side_clamp(size_h) * 32'(PX_BYTES);
	endfunction

	function automatic void emit_run(logic [pcx_rle_pkg::BYTE_W-1:0] value, int count);
		logic [31:0] lim;
		pix_word_t   w;
		lim = pixel_limit();
		while (count > 0 && bytes_out < lim) begin
			bytes_out++;
			count--;
			w.pixel = value;
			w.img_full = (bytes_out >= lim);
			w.run_end = (count == 0) || w.img_full;
			want_pixels.push_back(w);
		end
		if (bytes_out >= lim)
			full = 1'b1;
	endfunction

	function automatic void decode_word(code_word_t w);
		int count;
		if (w.sof) begin
			waiting_value = 1'b0;
			run_len = '0;
			bytes_out = '0;
			full = 1'b0;
		end
		// full image, or a size change left the counter past the limit
		if (full || bytes_out >= pixel_limit()) begin
			full = 1'b1;
			waiting_value = 1'b0;
			run_len = '0;
			return;
		end
		words_decoded++;
		if (waiting_value) begin
			count = int'(run_len);
			waiting_value = 1'b0;
			run_len = '0;
			emit_run(w.code, count);
		end else if ((w.code & pcx_rle_pkg::PREFIX_MASK) == pcx_rle_pkg::PREFIX_MASK) begin
			// a prefix that ends the stream is dropped
			if (!w.eos) begin
				waiting_value = 1'b1;
				run_len = w.code[5:0];
			end
		end else begin
			emit_run(w.code, 1);
		end
	endfunction

	task automatic report_error(input string msg);
		if (err_count < REPORT_MAX)
			$display("[%0t] ERROR: %s", $time, msg);
		err_count++;
	endtask

	task automatic send(input logic [pcx_rle_pkg::BYTE_W-1:0] code, input logic sof,
			input logic eos);
		code_word_t w;
		w.code = code;
		w.sof = sof;
		w.eos = eos;
		code_words.push_back(w);
		words_sent++;
	endtask

	// wait until every word is taken and every byte is back, then let the
	// block finish words that produce nothing
	task automatic drain();
		while (words_taken != words_sent || want_pixels.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic apb_access(input logic wr, input logic [pcx_rle_pkg::ADDR_W-1:0] addr,
			input apb_data_t wdata, output apb_data_t rdata);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= addr;
		pwdata <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic set_size(input size_t w, input size_t h);
		apb_data_t rd;
		apb_access(1'b1, WIDTH_ADDR, apb_data_t'(w), rd);
		size_w = w;
		apb_access(1'b1, HEIGHT_ADDR, apb_data_t'(h), rd);
		size_h = h;
		size_writes++;
		apb_access(1'b0, WIDTH_ADDR, '0, rd);
		if (rd !== apb_data_t'(w))
			report_error($sformatf("width readback %0h, wrote %0h", rd, w));
		apb_access(1'b0, HEIGHT_ADDR, '0, rd);
		if (rd !== apb_data_t'(h))
			report_error($sformatf("height readback %0h, wrote %0h", rd, h));
	endtask

	task automatic check_pixel();
		pix_word_t got;
		pix_word_t want;
		got.pixel = pix_if.pixel_byte;
		got.run_end = pix_if.last_of_run;
		got.img_full = pix_if.image_complete;
		pixels_checked++;
		if (want_pixels.size() == 0) begin
			report_error($sformatf("unexpected word: byte %02h last %b complete %b",
				got.pixel, got.run_end, got.img_full));
		end else begin
			want = want_pixels.pop_front();
			if (got !== want)
				report_error($sformatf(
					"word %0d: expected byte %02h last %b complete %b, got %02h %b %b",
					pixels_checked, want.pixel, want.run_end, want.img_full,
					got.pixel, got.run_end, got.img_full));
		end
		if (got.img_full === 1'b1)
			images_seen++;
	endtask

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// code word driver: bursts of random length with random gaps
	always @(posedge clk) begin
		if (arst_n) begin
			if (code_if.valid && code_if.ready) begin
				decode_word(on_bus);
				words_taken++;
			end
			if (!code_if.valid || code_if.ready) begin
				if (gap_left > 0) begin
					gap_left--;
					code_if.valid <= 1'b0;
				end else if (code_words.size() > 0) begin
					on_bus = code_words.pop_front();
					code_if.code_byte <= on_bus.code;
					code_if.start_of_image <= on_bus.sof;
					code_if.end_of_stream <= on_bus.eos;
					code_if.valid <= 1'b1;
					if (burst_left > 0) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(0, 24);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
					end
				end else begin
					code_if.valid <= 1'b0;
				end
			end
		end
	end

	// pixel monitor, receiver stalls follow a random ready pattern rerolled on wrap
	always @(posedge clk) begin
		if (arst_n) begin
			if (pix_if.valid && pix_if.ready)
				check_pixel();
			pix_if.ready <= ready_pat[pat_pos];
			pat_pos++;
			if (pat_pos == 16) begin
				pat_pos = 0;
				ready_pat = ($urandom_range(0, 2) == 0) ? 16'hFFFF : (16'($urandom) | 16'd1);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || psel || (code_if.valid && code_if.ready) || (pix_if.valid && pix_if.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles == WATCHDOG_LIMIT) begin
			$display("watchdog: no handshake for %0d cycles, %0d bytes still due",
				WATCHDOG_LIMIT, want_pixels.size());
			$display("** pcx_rle_decoder_top: FAILED **");
			$finish;
		end
	end

	initial begin
		int         r;
		int         n;
		int         base;
		logic       sof;
		logic [5:0] run;

		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		code_if.valid = 1'b0;
		code_if.code_byte = '0;
		code_if.start_of_image = 1'b0;
		code_if.end_of_stream = 1'b0;
		pix_if.ready = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// reset size: literals, zero run, longest run, prefix-like value byte
		send(8'h00, 1'b1, 1'b0);
		send(8'hBF, 1'b0, 1'b0);
		send(8'hC0, 1'b0, 1'b0);
		send(8'hFF, 1'b0, 1'b0);
		send(8'hFF, 1'b0, 1'b0);
		send(8'hAA, 1'b0, 1'b0);
		send(8'hC1, 1'b0, 1'b0);
		send(8'hC5, 1'b0, 1'b0);
		// dangling prefix at end of stream, decoding goes on after it
		send(8'hC3, 1'b0, 1'b1);
		send(8'h55, 1'b0, 1'b0);
		send(8'h2A, 1'b0, 1'b1);
		send(8'hC2, 1'b1, 1'b0);
		send(8'h11, 1'b0, 1'b0);
		drain();

		// one-pixel image: run cut at the limit, then input ignored
		set_size(size_t'(1), size_t'(1));
		send(8'hC5, 1'b1, 1'b0);
		send(8'h33, 1'b0, 1'b0);
		send(8'h44, 1'b1, 1'b0);
		send(8'h45, 1'b0, 1'b0);
		send(8'h46, 1'b0, 1'b0);
		send(8'hC2, 1'b0, 1'b0);
		drain();

		// shrink the image below what was already written
		set_size(size_t'(4), size_t'(1));
		send(8'h10, 1'b1, 1'b0);
		send(8'hC5, 1'b0, 1'b0);
		send(8'h20, 1'b0, 1'b0);
		drain();
		set_size(size_t'(1), size_t'(1));
		send(8'h30, 1'b0, 1'b0);
		send(8'h31, 1'b1, 1'b0);
		drain();

		// sizes out of range clamp to one and to the largest side
		set_size(size_t'(0), size_t'(0));
		send(8'hC4, 1'b1, 1'b0);
		send(8'h20, 1'b0, 1'b0);
		drain();
		set_size(size_t'(8191), size_t'(8191));
		send(8'h7E, 1'b1, 1'b0);
		drain();
		set_size(size_t'(SIDE_MAX), size_t'(SIDE_MAX));
		send(8'h80, 1'b1, 1'b0);
		drain();

		base = words_sent;
		while (words_sent < base + RANDOM_WORDS) begin
			r = $urandom_range(0, 99);
			if (r < 60)
				set_size(size_t'($urandom_range(1, 6)), size_t'($urandom_range(1, 3)));
			else if (r < 85)
				set_size(size_t'($urandom_range(1, 40)), size_t'($urandom_range(1, 10)));
			else if (r < 95)
				set_size(size_t'($urandom_range(0, 8191)), size_t'($urandom_range(0, 2)));
			n = $urandom_range(8, 40);
			sof = ($urandom_range(0, 4) != 0);
			for (int i = 0; i < n; i++) begin
				r = $urandom_range(0, 99);
				if (r < 50) begin
					send(8'($urandom_range(0, 8'hBF)), sof, $urandom_range(0, 19) == 0);
				end else if (r < 85) begin
					r = $urandom_range(0, 19);
					run = (r < 11) ? 6'($urandom_range(1, 4)) :
						(r < 16) ? 6'($urandom_range(5, 20)) :
						(r < 19) ? 6'($urandom_range(21, 63)) : 6'd0;
					send({pcx_rle_pkg::PREFIX_MASK[7:6], run}, sof, 1'b0);
					send(8'($urandom_range(0, 255)), $urandom_range(0, 29) == 0,
						$urandom_range(0, 19) == 0);
				end else if (r < 92) begin
					run = 6'($urandom_range(0, 63));
					send({pcx_rle_pkg::PREFIX_MASK[7:6], run}, sof, 1'b1);
				end else begin
					// noise: any byte with any flags
					send(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
						1'($urandom_range(0, 1)));
				end
				sof = ($urandom_range(0, 19) == 0);
			end
			drain();
		end
		drain();

		$display("%0d code words sent, %0d decoded, the rest ignored by a full image",
			words_sent, words_decoded);
		$display("%0d pixel bytes checked, %0d images completed over %0d sizes, %0d errors",
			pixels_checked, images_seen, size_writes, err_count);
		if (err_count == 0)
			$display("** pcx_rle_decoder_top: PASSED **");
		else
			$display("** pcx_rle_decoder_top: FAILED **");
		$finish;
	end

endmodule
